@@ src/u2b_pkg.sv @@
// Package for the UTF-8 to BMP decoder.
// Holds the byte masks, owed byte counts and fixed code units used by the decoder.
// Depends on nothing.
package u2b_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CodeWidth = 16;
   localparam int unsigned CountWidth = 2;

   localparam logic [ByteWidth-1:0] ContMask = 8'h3F;
   localparam logic [ByteWidth-1:0] TwoLeadMask = 8'h1F;
   localparam logic [ByteWidth-1:0] ThreeLeadMask = 8'h0F;

   localparam logic [CodeWidth-1:0] UnsupportedCode = 16'h003F;
   localparam logic [CodeWidth-1:0] TerminatorCode = 16'h0000;

   localparam logic [CountWidth-1:0] TwoByteOwed = 2'd1;
   localparam logic [CountWidth-1:0] ThreeByteOwed = 2'd2;
   localparam logic [CountWidth-1:0] SkipOwed = 2'd3;

endpackage

@@ src/u2b_if.sv @@
// Channel interfaces for the UTF-8 to BMP decoder: byte requests and code unit responses.
// Each carries valid, ready and its payload; widths come from u2b_pkg.
interface u2b_req_if;
   logic                           valid;
   logic                           ready;
   logic [u2b_pkg::ByteWidth-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface u2b_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [u2b_pkg::CodeWidth-1:0]  code_unit;
   logic                           end_of_string;

   modport source (output valid, output code_unit, output end_of_string, input ready);
   modport sink (input valid, input code_unit, input end_of_string, output ready);
endinterface

@@ src/utf8_to_bmp_decoder.sv @@
// Top level of the UTF-8 to BMP decoder.
// Uses u2b_pkg and the channel interfaces in u2b_if.sv.
//
//   channel  direction  payload                        role
//   req      in         in_byte[7:0]                   one UTF-8 byte per word
//   rsp      out        code_unit[15:0], end_of_string one code unit per word, or none
//
// A byte is taken in every cycle while the response register is empty or being drained.
// Its decoded code unit, if any, appears in the response register in the cycle after it is taken.
// The sequence state is updated in the cycle a byte is accepted; a stall on rsp holds
// the response in place and keeps req.ready low. Synchronous reset clears the sequence
// state and the response valid flag.
module utf8_to_bmp_decoder (
   input  logic          clock,
   input  logic          reset,
   u2b_req_if.sink       req,
   u2b_rsp_if.source     rsp
);

   logic [u2b_pkg::CountWidth-1:0] bytes_left_ff, bytes_left_in;
   logic                           skipping_ff, skipping_in;
   logic [u2b_pkg::CodeWidth-1:0]  partial_ff, partial_in;
   logic                           rsp_valid_ff;
   logic [u2b_pkg::CodeWidth-1:0]  code_ff;
   logic                           end_ff;

   logic [u2b_pkg::CountWidth-1:0] left_dec;
   logic                           accept;
   logic                           res_valid;
   logic [u2b_pkg::CodeWidth-1:0]  res_code;
   logic                           res_end;
   logic                           load;

   assign load = rsp.ready || !rsp_valid_ff;
   assign req.ready = load;
   assign accept = req.valid && load;
   assign left_dec = bytes_left_ff - u2b_pkg::CountWidth'(1);

   always_comb begin
      bytes_left_in = bytes_left_ff;
      skipping_in = skipping_ff;
      partial_in = partial_ff;
      res_valid = 1'b0;
      res_code = u2b_pkg::TerminatorCode;
      res_end = 1'b0;
      if (req.in_byte == '0) begin
         bytes_left_in = '0;
         skipping_in = 1'b0;
         partial_in = '0;
         res_valid = 1'b1;
         res_end = 1'b1;
      end else if (bytes_left_ff != '0) begin
         bytes_left_in = left_dec;
         if (skipping_ff) begin
            if (left_dec == '0) begin
               skipping_in = 1'b0;
            end
         end else begin
            partial_in = {partial_ff[u2b_pkg::CodeWidth-7:0],
                          req.in_byte[5:0] & u2b_pkg::ContMask[5:0]};
            if (left_dec == '0) begin
               res_valid = 1'b1;
               res_code = partial_in;
            end
         end
      end else begin
         skipping_in = 1'b0;
         case (req.in_byte) inside
            8'b0???????: begin
               res_valid = 1'b1;
               res_code = {8'h00, req.in_byte};
            end
            8'b110?????: begin
               partial_in = {11'd0, req.in_byte[4:0] & u2b_pkg::TwoLeadMask[4:0]};
               bytes_left_in = u2b_pkg::TwoByteOwed;
            end
            8'b1110????: begin
               partial_in = {12'd0, req.in_byte[3:0] & u2b_pkg::ThreeLeadMask[3:0]};
               bytes_left_in = u2b_pkg::ThreeByteOwed;
            end
            default: begin
               partial_in = '0;
               skipping_in = 1'b1;
               bytes_left_in = u2b_pkg::SkipOwed;
               res_valid = 1'b1;
               res_code = u2b_pkg::UnsupportedCode;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         skipping_ff <= 1'b0;
         partial_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            bytes_left_ff <= bytes_left_in;
            skipping_ff <= skipping_in;
            partial_ff <= partial_in;
         end
         if (load) begin
            rsp_valid_ff <= accept && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= res_code;
         end_ff <= res_end;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.code_unit = code_ff;
   assign rsp.end_of_string = end_ff;

endmodule
